/* sv/kms_pkg.sv */
package kms_pkg;

    localparam int NUM_HASHES_DEF = 128;
    localparam int SIG_W          = 32;
    localparam int CODE_W         = 5;
    localparam int PAIR_W         = 6;
    localparam int SLOT_W         = 7;
    localparam int PROD_W         = 48;

    localparam logic [15:0]      LEHMER_MULT = 16'd48271;
    localparam logic [SIG_W-1:0] LEHMER_MOD  = 32'h7FFF_FFFF;
    localparam logic [SIG_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [SIG_W-1:0] MASK_RESET  = 32'h00FF_FFFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;

    localparam logic [CODE_W-1:0] CODE_STAR = 5'd27;
    localparam logic [CODE_W-1:0] CODE_DASH = 5'd28;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_EMIT_EVEN,
        ST_EMIT_ODD,
        ST_EMIT_LOAD
    } t_state;

    typedef struct packed {
        logic start;
        logic hash;
        logic rd_even;
        logic rd_odd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic code_ok;
        logic last_item;
        logic step_last;
        logic pair_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } t_code;

    // Letters map to 1..26 in either case, then star and dash.
    function automatic t_code residue_code(input logic [7:0] ch);
        t_code r;
        r.ok   = 1'b1;
        r.code = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            r.code = CODE_W'(ch - CHAR_UPPER_A + 8'd1);
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            r.code = CODE_W'(ch - CHAR_LOWER_A + 8'd1);
        end else if (ch == CHAR_STAR) begin
            r.code = CODE_STAR;
        end else if (ch == CHAR_DASH) begin
            r.code = CODE_DASH;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

/* sv/kms_ram.sv */
module kms_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/kms_ctrl.sv */
module kms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kms_pkg::t_status  i_status,
    output kms_pkg::t_cmd     o_cmd
);

    kms_pkg::t_state r_state;
    kms_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            kms_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.code_ok) begin
                        n_state = kms_pkg::ST_HASH;
                    end else if (i_status.in_last) begin
                        n_state = kms_pkg::ST_EMIT_EVEN;
                    end
                end
            end
            kms_pkg::ST_HASH: begin
                o_cmd.hash = 1'b1;
                if (i_status.step_last) begin
                    n_state = i_status.last_item ? kms_pkg::ST_EMIT_EVEN : kms_pkg::ST_IDLE;
                end
            end
            kms_pkg::ST_EMIT_EVEN: begin
                o_cmd.rd_even = 1'b1;
                n_state       = kms_pkg::ST_EMIT_ODD;
            end
            kms_pkg::ST_EMIT_ODD: begin
                o_cmd.rd_odd = 1'b1;
                n_state      = kms_pkg::ST_EMIT_LOAD;
            end
            kms_pkg::ST_EMIT_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.pair_last ? kms_pkg::ST_IDLE : kms_pkg::ST_EMIT_EVEN;
                end
            end
            default: begin
                n_state = kms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/kms_datapath.sv */
module kms_datapath #(
    parameter int NUM_HASHES = kms_pkg::NUM_HASHES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kms_pkg::t_cmd                i_cmd,
    output kms_pkg::t_status             o_status,
    input  logic [7:0]                   i_residue,
    input  logic                         i_first_of_sequence,
    input  logic                         i_last_of_sequence,
    input  logic                         i_cfg_valid,
    input  logic [kms_pkg::SIG_W-1:0]    i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [kms_pkg::PAIR_W-1:0]   o_pair_index,
    output logic [kms_pkg::SIG_W-1:0]    o_even_signature,
    output logic [kms_pkg::SIG_W-1:0]    o_odd_signature,
    output logic                         o_bad_residue,
    output logic                         o_final_pair
);

    localparam int AW        = $clog2(NUM_HASHES);
    localparam int NUM_PAIRS = (NUM_HASHES + 1) / 2;
    localparam int SW        = kms_pkg::SIG_W;

    // Control state
    logic [SW-1:0]              r_kmer_mask;
    logic [SW-1:0]              r_kmer;
    logic                       r_err;
    logic                       r_last;
    logic [AW-1:0]              r_step;
    logic [kms_pkg::PAIR_W-1:0] r_pair;
    logic                       r_valid [NUM_HASHES];
    logic                       r_cmp_v;
    logic                       r_out_valid;

    // Payload
    logic [SW-1:0]              r_h;
    logic [SW-1:0]              r_cand;
    logic [AW-1:0]              r_wslot;
    logic                       r_rd_valid;
    logic                       r_rd_force;
    logic [SW-1:0]              r_even;
    logic [kms_pkg::PAIR_W-1:0] r_o_pair;
    logic [SW-1:0]              r_o_even;
    logic [SW-1:0]              r_o_odd;
    logic                       r_o_bad;
    logic                       r_o_final;

    kms_pkg::t_code               w_code;
    logic [SW-1:0]                w_base;
    logic [SW-1:0]                w_kmer_new;
    logic [kms_pkg::PROD_W-1:0]   w_prod;
    logic [SW-1:0]                w_fold;
    logic [SW-1:0]                w_h_next;
    logic [kms_pkg::SLOT_W-1:0]   w_even_slot;
    logic [kms_pkg::SLOT_W-1:0]   w_odd_slot;
    logic                         w_odd_in;
    logic                         w_re;
    logic                         w_any_rd;
    logic [AW-1:0]                w_raddr;
    logic [SW-1:0]                w_rdata;
    logic [SW-1:0]                w_rd_eff;
    logic                         w_we;
    logic                         w_pair_last;

    assign w_code     = kms_pkg::residue_code(i_residue);
    assign w_base     = i_first_of_sequence ? '0 : r_kmer;
    assign w_kmer_new = ((w_base << kms_pkg::CODE_W) + SW'(w_code.code)) & r_kmer_mask;

    // One Lehmer step: fold the 48-bit product at bit 31, then one subtract.
    assign w_prod   = {16'b0, r_h} * {32'b0, kms_pkg::LEHMER_MULT};
    assign w_fold   = SW'(w_prod[kms_pkg::PROD_W-1:31]) + {1'b0, w_prod[30:0]};
    assign w_h_next = (w_fold >= kms_pkg::LEHMER_MOD) ? (w_fold - kms_pkg::LEHMER_MOD) : w_fold;

    assign w_even_slot = {r_pair, 1'b0};
    assign w_odd_slot  = {r_pair, 1'b1};
    assign w_odd_in    = {1'b0, w_odd_slot} < (kms_pkg::SLOT_W + 1)'(NUM_HASHES);

    assign w_any_rd = i_cmd.hash | i_cmd.rd_even | i_cmd.rd_odd;
    assign w_re     = i_cmd.hash | i_cmd.rd_even | (i_cmd.rd_odd & w_odd_in);
    assign w_raddr  = i_cmd.hash    ? r_step :
                      i_cmd.rd_even ? w_even_slot[AW-1:0] : w_odd_slot[AW-1:0];

    // An entry never written since the last clear reads as all ones.
    assign w_rd_eff = (r_rd_valid && !r_rd_force) ? w_rdata : kms_pkg::ALL_ONES;
    assign w_we     = r_cmp_v && (r_cand < w_rd_eff);

    assign w_pair_last = r_pair == kms_pkg::PAIR_W'(NUM_PAIRS - 1);

    kms_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_HASHES)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata (r_cand),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_mask <= kms_pkg::MASK_RESET;
            r_kmer      <= '0;
            r_err       <= 1'b0;
            r_last      <= 1'b0;
            r_step      <= '0;
            r_pair      <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_HASHES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_kmer_mask <= i_cfg_data;
            end
            r_cmp_v <= i_cmd.hash;
            // The clear of a new sequence wins over a trailing write of the old one.
            if (i_cmd.start && i_first_of_sequence) begin
                for (int i = 0; i < NUM_HASHES; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end else if (w_we) begin
                r_valid[r_wslot] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_last <= i_last_of_sequence;
                r_step <= '0;
                r_pair <= '0;
                r_err  <= (r_err & !i_first_of_sequence) | !w_code.ok;
                if (w_code.ok) begin
                    r_kmer <= w_kmer_new;
                end else if (i_first_of_sequence) begin
                    r_kmer <= '0;
                end
            end
            if (i_cmd.hash) begin
                r_step <= r_step + AW'(1);
            end
            if (i_cmd.load) begin
                r_pair      <= r_pair + kms_pkg::PAIR_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_h <= w_kmer_new;
        end else if (i_cmd.hash) begin
            r_h <= w_h_next;
        end
        if (i_cmd.hash) begin
            r_cand  <= w_h_next;
            r_wslot <= r_step;
        end
        if (w_re) begin
            r_rd_valid <= r_valid[w_raddr];
        end
        if (w_any_rd) begin
            r_rd_force <= i_cmd.rd_odd & !w_odd_in;
        end
        if (i_cmd.rd_odd) begin
            r_even <= w_rd_eff;
        end
        if (i_cmd.load) begin
            r_o_pair  <= r_pair;
            r_o_even  <= r_even;
            r_o_odd   <= w_rd_eff;
            r_o_bad   <= r_err;
            r_o_final <= w_pair_last;
        end
    end

    assign o_status.in_last   = i_last_of_sequence;
    assign o_status.code_ok   = w_code.ok;
    assign o_status.last_item = r_last;
    assign o_status.step_last = r_step == AW'(NUM_HASHES - 1);
    assign o_status.pair_last = w_pair_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_pair_index     = r_o_pair;
    assign o_even_signature = r_o_even;
    assign o_odd_signature  = r_o_odd;
    assign o_bad_residue    = r_o_bad;
    assign o_final_pair     = r_o_final;

endmodule

/* sv/kmer_minhash_signer_core.sv */
// MinHash signer over rolling protein k-mers.
// Input channel (i_in_valid / o_in_ready): one residue character per item with
// first/last flags. A known character is shifted into the masked k-mer and
// drives a chain of NUM_HASHES Lehmer steps; each step updates one slot minimum.
// An item with a known character is accepted, then runs one multiply-fold step
// per cycle on the single shared multiplier; o_in_ready is high again right
// after the last step unless the item carries the last flag. An unknown
// character starts no hash chain and sets the sticky error flag.
// With the last flag set, (NUM_HASHES+1)/2 result items follow on the output
// channel (o_out_valid / i_out_ready), one pair of minimums each, made one at
// a time by two reads of the minimum RAM, then the output register load.
// The first pair shows after the even read, odd read and load states; o_final_pair marks the end.
// A stall on the output holds the output register and pauses the pair sequencer;
// no input item is taken until the last pair sits in the output register.
// Configuration (i_cfg_valid / i_cfg_data) writes the k-mer mask and is always
// ready; write it only while no item is in flight.
// Reset (i_rst_n low, synchronous) loads the mask 0xFFFFFF, clears the k-mer and
// the error flag, and invalidates all slot minimums at once (they read as all ones).
module kmer_minhash_signer_core #(
    parameter int NUM_HASHES = kms_pkg::NUM_HASHES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_residue,
    input  logic                         i_first_of_sequence,
    input  logic                         i_last_of_sequence,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [kms_pkg::SIG_W-1:0]    i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [kms_pkg::PAIR_W-1:0]   o_pair_index,
    output logic [kms_pkg::SIG_W-1:0]    o_even_signature,
    output logic [kms_pkg::SIG_W-1:0]    o_odd_signature,
    output logic                         o_bad_residue,
    output logic                         o_final_pair
);

    kms_pkg::t_cmd    w_cmd;
    kms_pkg::t_status w_status;

    // The mask register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequence accept, hash chain and pair emission.
    kms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // K-mer, Lehmer step, minimum RAM and output register.
    kms_datapath #(
        .NUM_HASHES (NUM_HASHES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_residue           (i_residue),
        .i_first_of_sequence (i_first_of_sequence),
        .i_last_of_sequence  (i_last_of_sequence),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pair_index        (o_pair_index),
        .o_even_signature    (o_even_signature),
        .o_odd_signature     (o_odd_signature),
        .o_bad_residue       (o_bad_residue),
        .o_final_pair        (o_final_pair)
    );

endmodule

/* sv/kms_checker.sv */
module kms_checker #(
    parameter int NUM_HASHES = kms_pkg::NUM_HASHES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [kms_pkg::PAIR_W-1:0]   o_pair_index,
    input logic [kms_pkg::SIG_W-1:0]    o_even_signature,
    input logic [kms_pkg::SIG_W-1:0]    o_odd_signature,
    input logic                         o_final_pair
);

    localparam int NUM_PAIRS = (NUM_HASHES + 1) / 2;
    localparam logic [kms_pkg::PAIR_W-1:0] LAST_PAIR = kms_pkg::PAIR_W'(NUM_PAIRS - 1);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped during stall");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pair_index) && $stable(o_even_signature)
            && $stable(o_odd_signature) && $stable(o_final_pair))
        else $error("output payload changed during stall");

    a_final_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_pair == (o_pair_index == LAST_PAIR)))
        else $error("final pair flag does not match the last pair index");

    // A slot minimum is either a reduced Lehmer value or untouched.
    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_even_signature[31] || o_even_signature == kms_pkg::ALL_ONES)
            && (!o_odd_signature[31] || o_odd_signature == kms_pkg::ALL_ONES))
        else $error("signature outside the Lehmer range");

endmodule

bind kmer_minhash_signer_core kms_checker #(
    .NUM_HASHES (NUM_HASHES)
) u_kms_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pair_index     (o_pair_index),
    .o_even_signature (o_even_signature),
    .o_odd_signature  (o_odd_signature),
    .o_final_pair     (o_final_pair)
);
